### rtl/core/dllce_pkg.sv
// Shared types, codes and constants of the linked list cursor engine.
`default_nettype none
package dllce_pkg;

  localparam int NODES_DEF = 64;

  localparam logic [3:0] FN_INS_FIRST  = 4'd0;
  localparam logic [3:0] FN_INS_LAST   = 4'd1;
  localparam logic [3:0] FN_FIRST      = 4'd2;
  localparam logic [3:0] FN_LAST       = 4'd3;
  localparam logic [3:0] FN_INS_AFTER  = 4'd4;
  localparam logic [3:0] FN_INS_BEFORE = 4'd5;
  localparam logic [3:0] FN_DEL_FIRST  = 4'd6;
  localparam logic [3:0] FN_DEL_LAST   = 4'd7;
  localparam logic [3:0] FN_DEL_AFTER  = 4'd8;
  localparam logic [3:0] FN_DEL_BEFORE = 4'd9;
  localparam logic [3:0] FN_GET_FIRST  = 4'd10;
  localparam logic [3:0] FN_GET_LAST   = 4'd11;
  localparam logic [3:0] FN_TOP_TERM   = 4'd12;
  localparam logic [3:0] FN_CLEAR      = 4'd13;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_NOP  = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [7:0] TERM_LOW   = 8'd36;
  localparam logic [7:0] TERM_HIGH  = 8'd47;
  localparam logic [7:0] TERM_EXTRA = 8'd105;

  typedef struct packed {
    logic [3:0] func;
    logic [7:0] data_in;
    logic       from_last;
  } in_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic [1:0] status;
    logic       cursor_valid;
  } out_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_ALLOC_RD,
    OP_TAKE_FREE,
    OP_TAKE_FRESH,
    OP_RD_CUR,
    OP_RD_HEAD,
    OP_RD_TAIL,
    OP_RD_X_NEXT,
    OP_RD_X_PREV,
    OP_INS_END,
    OP_INS_MID1,
    OP_INS_MID2,
    OP_DEL_FIRST,
    OP_DEL_LAST1,
    OP_DEL_MID1,
    OP_GIVE,
    OP_SET_CUR,
    OP_GET,
    OP_SRCH_INIT,
    OP_SRCH_RD,
    OP_SRCH_FOUND,
    OP_SRCH_STEP,
    OP_SRCH_FAIL,
    OP_CLEAR,
    OP_SET_NOP,
    OP_SET_ERR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] func;
    logic       cur_ok;
    logic       head_ok;
    logic       tail_ok;
    logic       free_ok;
    logic       fresh_ok;
    logic       cur_is_head;
    logic       cur_is_tail;
    logic       rnext_ok;
    logic       rprev_ok;
    logic       rsym_term;
  } dp_stat_t;

  function automatic logic is_term(input logic [7:0] s);
    is_term = ((s >= TERM_LOW) && (s <= TERM_HIGH)) || (s == TERM_EXTRA);
  endfunction

endpackage
`default_nettype wire

### rtl/core/dllce_dp.sv
// Datapath: node pool memories, list pointers and result registers.
`default_nettype none
module dllce_dp #(
  parameter int NODES = dllce_pkg::NODES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dllce_pkg::in_t    in_item,
  input  wire dllce_pkg::dp_cmd_t cmd,
  output dllce_pkg::dp_stat_t    stat,
  output dllce_pkg::out_t        out_item
);

  localparam int PW = $clog2(NODES + 1);
  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam logic [PW-1:0] NIL = PW'(NODES);

  function automatic logic [PW-1:0] sat(input logic [PW-1:0] p);
    sat = (p < NIL) ? p : NIL;
  endfunction

  logic [7:0]    sym_mem [NODES];
  logic [PW-1:0] fwd_mem [NODES];
  logic [PW-1:0] bwd_mem [NODES];

  logic [PW-1:0] head_r, head_nxt, tail_r, tail_nxt, cur_r, cur_nxt;
  logic [PW-1:0] free_r, free_nxt, fresh_r, fresh_nxt;
  logic [PW-1:0] n_r, n_nxt, c_r, c_nxt, x_r, x_nxt;
  logic [3:0]    func_r, func_nxt;
  logic [7:0]    din_r, din_nxt;
  logic          fl_r, fl_nxt;
  logic [7:0]    dout_r, dout_nxt;
  logic [1:0]    stat_r, stat_nxt;

  logic [7:0]    rsym_r;
  logic [PW-1:0] rfwd_r, rbwd_r;
  logic          rd_en;
  logic [PW-1:0] rd_addr;

  logic          sym_we, fwd_we, bwd_we;
  logic [PW-1:0] sym_wa, fwd_wa, bwd_wa;
  logic [7:0]    sym_wd;
  logic [PW-1:0] fwd_wd, bwd_wd;

  logic [PW-1:0] rnext, rprev;

  assign rnext = sat(rfwd_r);
  assign rprev = sat(rbwd_r);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cur_nxt   = cur_r;
    free_nxt  = free_r;
    fresh_nxt = fresh_r;
    n_nxt     = n_r;
    c_nxt     = c_r;
    x_nxt     = x_r;
    func_nxt  = func_r;
    din_nxt   = din_r;
    fl_nxt    = fl_r;
    dout_nxt  = dout_r;
    stat_nxt  = stat_r;
    rd_en     = 1'b0;
    rd_addr   = '0;
    sym_we    = 1'b0;
    sym_wa    = '0;
    sym_wd    = din_r;
    fwd_we    = 1'b0;
    fwd_wa    = '0;
    fwd_wd    = NIL;
    bwd_we    = 1'b0;
    bwd_wa    = '0;
    bwd_wd    = NIL;
    case (cmd.op)
      dllce_pkg::OP_LOAD: begin
        func_nxt = in_item.func;
        din_nxt  = in_item.data_in;
        fl_nxt   = in_item.from_last;
        dout_nxt = '0;
        stat_nxt = dllce_pkg::ST_DONE;
      end
      dllce_pkg::OP_ALLOC_RD: begin
        rd_en   = 1'b1;
        rd_addr = free_r;
      end
      dllce_pkg::OP_TAKE_FREE: begin
        n_nxt    = free_r;
        free_nxt = rnext;
      end
      dllce_pkg::OP_TAKE_FRESH: begin
        n_nxt     = fresh_r;
        fresh_nxt = fresh_r + PW'(1);
      end
      dllce_pkg::OP_RD_CUR: begin
        c_nxt   = cur_r;
        rd_en   = 1'b1;
        rd_addr = cur_r;
      end
      dllce_pkg::OP_RD_HEAD: begin
        x_nxt   = head_r;
        rd_en   = 1'b1;
        rd_addr = head_r;
      end
      dllce_pkg::OP_RD_TAIL: begin
        x_nxt   = tail_r;
        rd_en   = 1'b1;
        rd_addr = tail_r;
      end
      dllce_pkg::OP_RD_X_NEXT: begin
        x_nxt   = rnext;
        rd_en   = 1'b1;
        rd_addr = rnext;
      end
      dllce_pkg::OP_RD_X_PREV: begin
        x_nxt   = rprev;
        rd_en   = 1'b1;
        rd_addr = rprev;
      end
      dllce_pkg::OP_INS_END: begin
        // new node only; the neighbor link follows next cycle since each
        // array has a single write port
        sym_we = 1'b1;
        sym_wa = n_r;
        fwd_we = 1'b1;
        fwd_wa = n_r;
        bwd_we = 1'b1;
        bwd_wa = n_r;
        if (func_r == dllce_pkg::FN_INS_FIRST) begin
          fwd_wd = head_r;
          bwd_wd = NIL;
        end else begin
          fwd_wd = NIL;
          bwd_wd = tail_r;
        end
      end
      dllce_pkg::OP_INS_MID1: begin
        sym_we = 1'b1;
        sym_wa = n_r;
        fwd_we = 1'b1;
        fwd_wa = n_r;
        bwd_we = 1'b1;
        bwd_wa = n_r;
        if (func_r == dllce_pkg::FN_INS_AFTER) begin
          fwd_wd = rnext;
          bwd_wd = c_r;
        end else begin
          fwd_wd = c_r;
          bwd_wd = rprev;
        end
      end
      dllce_pkg::OP_INS_MID2: begin
        case (func_r)
          dllce_pkg::FN_INS_FIRST: begin
            if (head_r != NIL) begin
              bwd_we = 1'b1;
              bwd_wa = head_r;
              bwd_wd = n_r;
            end else begin
              tail_nxt = n_r;
            end
            head_nxt = n_r;
          end
          dllce_pkg::FN_INS_LAST: begin
            if (tail_r != NIL) begin
              fwd_we = 1'b1;
              fwd_wa = tail_r;
              fwd_wd = n_r;
            end else begin
              head_nxt = n_r;
            end
            tail_nxt = n_r;
          end
          dllce_pkg::FN_INS_AFTER: begin
            fwd_we = 1'b1;
            fwd_wa = c_r;
            fwd_wd = n_r;
            if (c_r == tail_r) begin
              tail_nxt = n_r;
            end else if (rnext != NIL) begin
              bwd_we = 1'b1;
              bwd_wa = rnext;
              bwd_wd = n_r;
            end
          end
          default: begin
            bwd_we = 1'b1;
            bwd_wa = c_r;
            bwd_wd = n_r;
            if (c_r == head_r) begin
              head_nxt = n_r;
            end else if (rprev != NIL) begin
              fwd_we = 1'b1;
              fwd_wa = rprev;
              fwd_wd = n_r;
            end
          end
        endcase
      end
      dllce_pkg::OP_DEL_FIRST: begin
        if (cur_r == x_r) cur_nxt = NIL;
        head_nxt = rnext;
        if (rnext != NIL) begin
          bwd_we = 1'b1;
          bwd_wa = rnext;
          bwd_wd = NIL;
        end else begin
          tail_nxt = NIL;
        end
        dout_nxt = rsym_r;
        fwd_we   = 1'b1;
        fwd_wa   = x_r;
        fwd_wd   = free_r;
        free_nxt = x_r;
      end
      dllce_pkg::OP_DEL_LAST1: begin
        if (cur_r == x_r) cur_nxt = NIL;
        tail_nxt = rprev;
        if (rprev != NIL) begin
          fwd_we = 1'b1;
          fwd_wa = rprev;
          fwd_wd = NIL;
        end else begin
          head_nxt = NIL;
        end
        dout_nxt = rsym_r;
      end
      dllce_pkg::OP_DEL_MID1: begin
        dout_nxt = rsym_r;
        if (func_r == dllce_pkg::FN_DEL_AFTER) begin
          fwd_we = 1'b1;
          fwd_wa = c_r;
          fwd_wd = rnext;
          if (x_r == tail_r) begin
            tail_nxt = c_r;
          end else if (rnext != NIL) begin
            bwd_we = 1'b1;
            bwd_wa = rnext;
            bwd_wd = c_r;
          end
        end else begin
          bwd_we = 1'b1;
          bwd_wa = c_r;
          bwd_wd = rprev;
          if (x_r == head_r) begin
            head_nxt = c_r;
          end else if (rprev != NIL) begin
            fwd_we = 1'b1;
            fwd_wa = rprev;
            fwd_wd = c_r;
          end
        end
      end
      dllce_pkg::OP_GIVE: begin
        fwd_we   = 1'b1;
        fwd_wa   = x_r;
        fwd_wd   = free_r;
        free_nxt = x_r;
      end
      dllce_pkg::OP_SET_CUR: begin
        cur_nxt = (func_r == dllce_pkg::FN_FIRST) ? head_r : tail_r;
        if (cur_nxt == NIL) stat_nxt = dllce_pkg::ST_NOP;
      end
      dllce_pkg::OP_GET: begin
        dout_nxt = rsym_r;
      end
      dllce_pkg::OP_SRCH_INIT: begin
        if (fl_r) cur_nxt = tail_r;
      end
      dllce_pkg::OP_SRCH_RD: begin
        rd_en   = 1'b1;
        rd_addr = cur_r;
      end
      dllce_pkg::OP_SRCH_FOUND: begin
        dout_nxt = rsym_r;
        stat_nxt = dllce_pkg::ST_DONE;
      end
      dllce_pkg::OP_SRCH_STEP: begin
        cur_nxt = rprev;
      end
      dllce_pkg::OP_SRCH_FAIL: begin
        cur_nxt  = NIL;
        stat_nxt = dllce_pkg::ST_NOP;
      end
      dllce_pkg::OP_CLEAR: begin
        head_nxt  = NIL;
        tail_nxt  = NIL;
        cur_nxt   = NIL;
        free_nxt  = NIL;
        fresh_nxt = '0;
      end
      dllce_pkg::OP_SET_NOP: stat_nxt = dllce_pkg::ST_NOP;
      dllce_pkg::OP_SET_ERR: stat_nxt = dllce_pkg::ST_ERR;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= NIL;
      tail_r  <= NIL;
      cur_r   <= NIL;
      free_r  <= NIL;
      fresh_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cur_r   <= cur_nxt;
      free_r  <= free_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    c_r    <= c_nxt;
    x_r    <= x_nxt;
    func_r <= func_nxt;
    din_r  <= din_nxt;
    fl_r   <= fl_nxt;
    dout_r <= dout_nxt;
    stat_r <= stat_nxt;
  end

  // node pool: one write per array, one shared read address, registered data
  always_ff @(posedge clk) begin
    if (sym_we) sym_mem[sym_wa[AW-1:0]] <= sym_wd;
    if (fwd_we) fwd_mem[fwd_wa[AW-1:0]] <= fwd_wd;
    if (bwd_we) bwd_mem[bwd_wa[AW-1:0]] <= bwd_wd;
    if (rd_en) begin
      rsym_r <= sym_mem[rd_addr[AW-1:0]];
      rfwd_r <= fwd_mem[rd_addr[AW-1:0]];
      rbwd_r <= bwd_mem[rd_addr[AW-1:0]];
    end
  end

  assign stat.func        = func_r;
  assign stat.cur_ok      = (cur_r != NIL);
  assign stat.head_ok     = (head_r != NIL);
  assign stat.tail_ok     = (tail_r != NIL);
  assign stat.free_ok     = (free_r != NIL);
  assign stat.fresh_ok    = (fresh_r < NIL);
  assign stat.cur_is_head = (cur_r == head_r);
  assign stat.cur_is_tail = (cur_r == tail_r);
  assign stat.rnext_ok    = (rnext != NIL);
  assign stat.rprev_ok    = (rprev != NIL);
  assign stat.rsym_term   = dllce_pkg::is_term(rsym_r);

  assign out_item.data_out     = dout_r;
  assign out_item.status       = stat_r;
  assign out_item.cursor_valid = (cur_r != NIL);

endmodule
`default_nettype wire

### rtl/core/dllce_ctrl.sv
// Controller: sequences each request into datapath steps.
`default_nettype none
module dllce_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire dllce_pkg::dp_stat_t stat,
  output logic                    busy,
  output logic                    out_valid,
  output dllce_pkg::dp_cmd_t      cmd
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_DISP     = 12'b0000_0000_0010,
    S_ALLOC_W  = 12'b0000_0000_0100,
    S_RDC      = 12'b0000_0000_1000,
    S_INS_E    = 12'b0000_0001_0000,
    S_RD_W1    = 12'b0000_0010_0000,
    S_INS_M2   = 12'b0000_0100_0000,
    S_RD_W2    = 12'b0000_1000_0000,
    S_GIVE     = 12'b0001_0000_0000,
    S_SRCH_CHK = 12'b0010_0000_0000,
    S_SRCH_W   = 12'b0100_0000_0000,
    S_FIN      = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = dllce_pkg::OP_NOP;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = dllce_pkg::OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_FIN;
        case (stat.func)
          dllce_pkg::FN_INS_FIRST, dllce_pkg::FN_INS_LAST,
          dllce_pkg::FN_INS_AFTER, dllce_pkg::FN_INS_BEFORE: begin
            if ((stat.func == dllce_pkg::FN_INS_AFTER ||
                 stat.func == dllce_pkg::FN_INS_BEFORE) && !stat.cur_ok) begin
              cmd.op = dllce_pkg::OP_SET_NOP;
            end else if (stat.free_ok) begin
              cmd.op    = dllce_pkg::OP_ALLOC_RD;
              state_nxt = S_ALLOC_W;
            end else if (stat.fresh_ok) begin
              cmd.op    = dllce_pkg::OP_TAKE_FRESH;
              state_nxt = (stat.func == dllce_pkg::FN_INS_FIRST ||
                           stat.func == dllce_pkg::FN_INS_LAST) ? S_INS_E : S_RDC;
            end else begin
              cmd.op = dllce_pkg::OP_SET_ERR;
            end
          end
          dllce_pkg::FN_FIRST, dllce_pkg::FN_LAST: cmd.op = dllce_pkg::OP_SET_CUR;
          dllce_pkg::FN_DEL_FIRST: begin
            if (stat.head_ok) begin
              cmd.op    = dllce_pkg::OP_RD_HEAD;
              state_nxt = S_RD_W1;
            end else begin
              cmd.op = dllce_pkg::OP_SET_NOP;
            end
          end
          dllce_pkg::FN_DEL_LAST: begin
            if (stat.tail_ok) begin
              cmd.op    = dllce_pkg::OP_RD_TAIL;
              state_nxt = S_RD_W1;
            end else begin
              cmd.op = dllce_pkg::OP_SET_NOP;
            end
          end
          dllce_pkg::FN_DEL_AFTER: begin
            if (!stat.cur_ok || stat.cur_is_tail) begin
              cmd.op = dllce_pkg::OP_SET_NOP;
            end else begin
              cmd.op    = dllce_pkg::OP_RD_CUR;
              state_nxt = S_RD_W1;
            end
          end
          dllce_pkg::FN_DEL_BEFORE: begin
            if (!stat.cur_ok || stat.cur_is_head) begin
              cmd.op = dllce_pkg::OP_SET_NOP;
            end else begin
              cmd.op    = dllce_pkg::OP_RD_CUR;
              state_nxt = S_RD_W1;
            end
          end
          dllce_pkg::FN_GET_FIRST: begin
            if (stat.head_ok) begin
              cmd.op    = dllce_pkg::OP_RD_HEAD;
              state_nxt = S_RD_W1;
            end else begin
              cmd.op = dllce_pkg::OP_SET_ERR;
            end
          end
          dllce_pkg::FN_GET_LAST: begin
            if (stat.tail_ok) begin
              cmd.op    = dllce_pkg::OP_RD_TAIL;
              state_nxt = S_RD_W1;
            end else begin
              cmd.op = dllce_pkg::OP_SET_ERR;
            end
          end
          dllce_pkg::FN_TOP_TERM: begin
            if (stat.tail_ok) begin
              cmd.op    = dllce_pkg::OP_SRCH_INIT;
              state_nxt = S_SRCH_CHK;
            end else begin
              cmd.op = dllce_pkg::OP_SET_NOP;
            end
          end
          dllce_pkg::FN_CLEAR: cmd.op = dllce_pkg::OP_CLEAR;
          default: cmd.op = dllce_pkg::OP_SET_NOP;
        endcase
      end
      S_ALLOC_W: begin
        cmd.op    = dllce_pkg::OP_TAKE_FREE;
        state_nxt = (stat.func == dllce_pkg::FN_INS_FIRST ||
                     stat.func == dllce_pkg::FN_INS_LAST) ? S_INS_E : S_RDC;
      end
      S_RDC: begin
        cmd.op    = dllce_pkg::OP_RD_CUR;
        state_nxt = S_RD_W1;
      end
      S_INS_E: begin
        cmd.op    = dllce_pkg::OP_INS_END;
        state_nxt = S_INS_M2;
      end
      S_RD_W1: begin
        state_nxt = S_FIN;
        case (stat.func)
          dllce_pkg::FN_INS_AFTER, dllce_pkg::FN_INS_BEFORE: begin
            cmd.op    = dllce_pkg::OP_INS_MID1;
            state_nxt = S_INS_M2;
          end
          dllce_pkg::FN_DEL_FIRST: cmd.op = dllce_pkg::OP_DEL_FIRST;
          dllce_pkg::FN_DEL_LAST: begin
            cmd.op    = dllce_pkg::OP_DEL_LAST1;
            state_nxt = S_GIVE;
          end
          dllce_pkg::FN_DEL_AFTER: begin
            if (stat.rnext_ok) begin
              cmd.op    = dllce_pkg::OP_RD_X_NEXT;
              state_nxt = S_RD_W2;
            end else begin
              cmd.op = dllce_pkg::OP_SET_NOP;
            end
          end
          dllce_pkg::FN_DEL_BEFORE: begin
            if (stat.rprev_ok) begin
              cmd.op    = dllce_pkg::OP_RD_X_PREV;
              state_nxt = S_RD_W2;
            end else begin
              cmd.op = dllce_pkg::OP_SET_NOP;
            end
          end
          default: cmd.op = dllce_pkg::OP_GET;
        endcase
      end
      S_INS_M2: begin
        cmd.op    = dllce_pkg::OP_INS_MID2;
        state_nxt = S_FIN;
      end
      S_RD_W2: begin
        cmd.op    = dllce_pkg::OP_DEL_MID1;
        state_nxt = S_GIVE;
      end
      S_GIVE: begin
        cmd.op    = dllce_pkg::OP_GIVE;
        state_nxt = S_FIN;
      end
      S_SRCH_CHK: begin
        if (stat.cur_ok) begin
          cmd.op    = dllce_pkg::OP_SRCH_RD;
          state_nxt = S_SRCH_W;
        end else begin
          cmd.op    = dllce_pkg::OP_SRCH_FAIL;
          state_nxt = S_FIN;
        end
      end
      S_SRCH_W: begin
        if (stat.rsym_term) begin
          cmd.op    = dllce_pkg::OP_SRCH_FOUND;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = dllce_pkg::OP_SRCH_STEP;
          state_nxt = S_SRCH_CHK;
        end
      end
      S_FIN: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_FIN);

endmodule
`default_nettype wire

### rtl/core/doubly_linked_list_cursor_engine.sv
// Top level: linked list cursor engine, controller plus datapath.
// Sequencing: each request walks its function's controller steps from the
//   accepting edge to the result strobe; the top-terminal search tests one
//   node at a time, walking back, until a hit or a miss. The single shared read
//   port of the node pool (read then write per pointer update, one write per
//   array per cycle) sets the steps. One transaction at a time: busy stays
//   high through the strobe cycle; the next accept can come in the cycle after.
// Reset: synchronous active-low rst_n empties the list; pool contents stay.
`default_nettype none
module doubly_linked_list_cursor_engine #(
  parameter int NODES = dllce_pkg::NODES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire dllce_pkg::in_t in_item,
  output logic                out_valid,
  output dllce_pkg::out_t     out_item
);

  // command / status link between sequencer and datapath
  dllce_pkg::dp_cmd_t  cmd;
  dllce_pkg::dp_stat_t stat;

  // controller: decodes the func code, walks the micro-steps of each
  // transaction and raises out_valid for one cycle at the end
  dllce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // datapath: node pool (symbol, forward and back link arrays), head, tail,
  // cursor, free chain and fresh count, plus the result registers
  dllce_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule
`default_nettype wire

### rtl/core/dllce_chk.sv
// Port-level checker for the linked list cursor engine, bound to the top.
`default_nettype none
module dllce_chk (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            start,
  input wire logic            busy,
  input wire logic            out_valid,
  input wire dllce_pkg::out_t out_item
);

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result strobe outside a transaction");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted transaction not busy");

  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> $past(out_valid)) else $error("transaction ended without result");

  a_one_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status == dllce_pkg::ST_DONE ||
                   out_item.status == dllce_pkg::ST_NOP ||
                   out_item.status == dllce_pkg::ST_ERR))
    else $error("bad status code");

endmodule

bind doubly_linked_list_cursor_engine dllce_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the linked list cursor engine.
`timescale 1ns / 1ps
module tb;

  localparam int NPOOL = dllce_pkg::NODES_DEF;
  localparam logic [6:0] NIL = 7'(NPOOL);

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  dllce_pkg::in_t  in_item;
  logic            out_valid;
  dllce_pkg::out_t out_item;

  doubly_linked_list_cursor_engine u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

  // Shadow copy of the list kept by the predictor.
  logic [7:0] sym_mem [NPOOL];
  logic [6:0] nxt_mem [NPOOL];
  logic [6:0] prv_mem [NPOOL];
  logic [6:0] head_p, tail_p, cur_p, free_p, fresh_n;
  int         list_len;

  dllce_pkg::out_t expected_q[$];
  int              err_cnt;

  function automatic logic [6:0] alloc_node();
    logic [6:0] n;
    if (free_p != NIL) begin
      n = free_p;
      free_p = nxt_mem[n];
      if (free_p >= NIL) free_p = NIL;
      return n;
    end
    if (fresh_n < NIL) begin
      n = fresh_n;
      fresh_n = fresh_n + 7'd1;
      return n;
    end
    return NIL;
  endfunction

  function automatic void release_node(logic [6:0] p);
    nxt_mem[p] = free_p;
    free_p = p;
    list_len--;
  endfunction

  function automatic logic term_sym(logic [7:0] s);
    return (s >= 8'd36 && s <= 8'd47) || s == 8'd105;
  endfunction

  // Apply one transaction to the shadow list and return the predicted result.
  function automatic dllce_pkg::out_t list_step(dllce_pkg::in_t t);
    dllce_pkg::out_t r;
    logic [6:0] n, c, x;
    r = '0;
    r.status = dllce_pkg::ST_DONE;
    case (t.func)
      dllce_pkg::FN_INS_FIRST, dllce_pkg::FN_INS_LAST: begin
        n = alloc_node();
        if (n == NIL) r.status = dllce_pkg::ST_ERR;
        else begin
          list_len++;
          sym_mem[n] = t.data_in;
          if (t.func == dllce_pkg::FN_INS_FIRST) begin
            prv_mem[n] = NIL;
            nxt_mem[n] = head_p;
            if (head_p != NIL) prv_mem[head_p] = n; else tail_p = n;
            head_p = n;
          end else begin
            nxt_mem[n] = NIL;
            prv_mem[n] = tail_p;
            if (tail_p != NIL) nxt_mem[tail_p] = n; else head_p = n;
            tail_p = n;
          end
        end
      end
      dllce_pkg::FN_FIRST, dllce_pkg::FN_LAST: begin
        cur_p = (t.func == dllce_pkg::FN_FIRST) ? head_p : tail_p;
        if (cur_p == NIL) r.status = dllce_pkg::ST_NOP;
      end
      dllce_pkg::FN_INS_AFTER, dllce_pkg::FN_INS_BEFORE: begin
        c = cur_p;
        if (c == NIL) r.status = dllce_pkg::ST_NOP;
        else begin
          n = alloc_node();
          if (n == NIL) r.status = dllce_pkg::ST_ERR;
          else begin
            list_len++;
            sym_mem[n] = t.data_in;
            if (t.func == dllce_pkg::FN_INS_AFTER) begin
              nxt_mem[n] = nxt_mem[c];
              prv_mem[n] = c;
              nxt_mem[c] = n;
              if (c == tail_p) tail_p = n;
              else if (nxt_mem[n] != NIL) prv_mem[nxt_mem[n]] = n;
            end else begin
              prv_mem[n] = prv_mem[c];
              nxt_mem[n] = c;
              prv_mem[c] = n;
              if (c == head_p) head_p = n;
              else if (prv_mem[n] != NIL) nxt_mem[prv_mem[n]] = n;
            end
          end
        end
      end
      dllce_pkg::FN_DEL_FIRST: begin
        x = head_p;
        if (x == NIL) r.status = dllce_pkg::ST_NOP;
        else begin
          if (cur_p == x) cur_p = NIL;
          head_p = nxt_mem[x];
          if (head_p != NIL) prv_mem[head_p] = NIL;
          else tail_p = NIL;
          r.data_out = sym_mem[x];
          release_node(x);
        end
      end
      dllce_pkg::FN_DEL_LAST: begin
        x = tail_p;
        if (x == NIL) r.status = dllce_pkg::ST_NOP;
        else begin
          if (cur_p == x) cur_p = NIL;
          tail_p = prv_mem[x];
          if (tail_p != NIL) nxt_mem[tail_p] = NIL;
          else head_p = NIL;
          r.data_out = sym_mem[x];
          release_node(x);
        end
      end
      dllce_pkg::FN_DEL_AFTER: begin
        c = cur_p;
        if (c == NIL || c == tail_p) r.status = dllce_pkg::ST_NOP;
        else begin
          x = nxt_mem[c];
          nxt_mem[c] = nxt_mem[x];
          if (x == tail_p) tail_p = c;
          else prv_mem[nxt_mem[x]] = c;
          r.data_out = sym_mem[x];
          release_node(x);
        end
      end
      dllce_pkg::FN_DEL_BEFORE: begin
        c = cur_p;
        if (c == NIL || c == head_p) r.status = dllce_pkg::ST_NOP;
        else begin
          x = prv_mem[c];
          prv_mem[c] = prv_mem[x];
          if (x == head_p) head_p = c;
          else nxt_mem[prv_mem[x]] = c;
          r.data_out = sym_mem[x];
          release_node(x);
        end
      end
      dllce_pkg::FN_GET_FIRST, dllce_pkg::FN_GET_LAST: begin
        x = (t.func == dllce_pkg::FN_GET_FIRST) ? head_p : tail_p;
        if (x == NIL) r.status = dllce_pkg::ST_ERR;
        else r.data_out = sym_mem[x];
      end
      dllce_pkg::FN_TOP_TERM: begin
        if (tail_p == NIL) r.status = dllce_pkg::ST_NOP;
        else begin
          if (t.from_last) cur_p = tail_p;
          r.status = dllce_pkg::ST_NOP;
          while (cur_p != NIL) begin
            if (term_sym(sym_mem[cur_p])) begin
              r.data_out = sym_mem[cur_p];
              r.status = dllce_pkg::ST_DONE;
              break;
            end
            cur_p = prv_mem[cur_p];
          end
          if (r.status != dllce_pkg::ST_DONE) cur_p = NIL;
        end
      end
      dllce_pkg::FN_CLEAR: begin
        head_p = NIL; tail_p = NIL; cur_p = NIL; free_p = NIL; fresh_n = '0;
        list_len = 0;
      end
      default: r.status = dllce_pkg::ST_NOP;
    endcase
    r.cursor_valid = (cur_p != NIL);
    return r;
  endfunction

  // Result checker: the engine cannot be held off, so sample every strobe.
  always @(posedge clk) begin
    dllce_pkg::out_t e;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $error("result with no transaction outstanding");
        err_cnt++;
      end else begin
        e = expected_q.pop_front();
        if (out_item.data_out !== e.data_out) begin
          $error("data_out: expected %0d, actual %0d", e.data_out, out_item.data_out);
          err_cnt++;
        end
        if (out_item.status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_item.status);
          err_cnt++;
        end
        if (out_item.cursor_valid !== e.cursor_valid) begin
          $error("cursor_valid: expected %0d, actual %0d", e.cursor_valid,
                 out_item.cursor_valid);
          err_cnt++;
        end
      end
    end
  end

  // Send one transaction; start drops only if the next one waits.
  task automatic send_txn(dllce_pkg::in_t t, bit use_gap, bit has_gold,
                          dllce_pkg::out_t gold);
    int gap;
    dllce_pkg::out_t p;
    gap = use_gap ? $urandom_range(0, 13) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = list_step(t);
    if (has_gold && p !== gold) begin
      $error("directed row func %0d: predictor disagrees with table", t.func);
      err_cnt++;
    end
    expected_q.push_back(has_gold ? gold : p);
    @(negedge clk);
  endtask

  typedef struct {
    dllce_pkg::in_t  t;
    bit              has_gold;
    dllce_pkg::out_t gold;
  } row_t;

  function automatic row_t mk(logic [3:0] f, logic [7:0] d, logic fl, bit g,
                              logic [7:0] gd, logic [1:0] gs, logic gc);
    row_t r;
    r.t = '{func: f, data_in: d, from_last: fl};
    r.has_gold = g;
    r.gold = '{data_out: gd, status: gs, cursor_valid: gc};
    return r;
  endfunction

  // Random transaction biased toward the operations that keep the list busy.
  function automatic dllce_pkg::in_t rand_txn();
    dllce_pkg::in_t t;
    int             w;
    w = $urandom_range(0, 99);
    if (w < 30)
      t.func = ($urandom_range(0, 1)) ? dllce_pkg::FN_INS_LAST : dllce_pkg::FN_INS_FIRST;
    else if (w < 45)
      t.func = ($urandom_range(0, 1)) ? dllce_pkg::FN_INS_AFTER : dllce_pkg::FN_INS_BEFORE;
    else if (w < 55)
      t.func = ($urandom_range(0, 1)) ? dllce_pkg::FN_FIRST : dllce_pkg::FN_LAST;
    else if (w < 75) t.func = 4'($urandom_range(6, 9));
    else if (w < 82)
      t.func = ($urandom_range(0, 1)) ? dllce_pkg::FN_GET_FIRST : dllce_pkg::FN_GET_LAST;
    else if (w < 95) t.func = dllce_pkg::FN_TOP_TERM;
    else if (w < 97) t.func = dllce_pkg::FN_CLEAR;
    else t.func = 4'($urandom_range(14, 15));
    if (list_len > 40 &&
        t.func inside {dllce_pkg::FN_INS_FIRST, dllce_pkg::FN_INS_LAST} &&
        $urandom_range(0, 1)) t.func = dllce_pkg::FN_DEL_LAST;
    // Keep terminal symbols common so searches land on a hit often.
    t.data_in = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(36, 47)) :
                8'($urandom_range(0, 255));
    t.from_last = 1'($urandom_range(0, 1));
    return t;
  endfunction

  initial begin
    row_t dir[$];
    int   k;
    err_cnt  = 0;
    head_p = NIL; tail_p = NIL; cur_p = NIL; free_p = NIL; fresh_n = '0;
    list_len = 0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty-list corner cases, extremes of the symbol byte, cursor edits, searches, a clear.
    dir.push_back(mk(dllce_pkg::FN_GET_FIRST,  8'd0,   1'b0, 1, 8'd0,
                     dllce_pkg::ST_ERR, 1'b0));
    dir.push_back(mk(dllce_pkg::FN_GET_LAST,   8'd0,   1'b0, 1, 8'd0,
                     dllce_pkg::ST_ERR, 1'b0));
    dir.push_back(mk(dllce_pkg::FN_DEL_FIRST,  8'd0,   1'b0, 1, 8'd0,
                     dllce_pkg::ST_NOP, 1'b0));
    dir.push_back(mk(dllce_pkg::FN_DEL_LAST,   8'd0,   1'b0, 1, 8'd0,
                     dllce_pkg::ST_NOP, 1'b0));
    dir.push_back(mk(dllce_pkg::FN_FIRST,      8'd0,   1'b0, 1, 8'd0,
                     dllce_pkg::ST_NOP, 1'b0));
    dir.push_back(mk(dllce_pkg::FN_INS_AFTER,  8'd5,   1'b0, 1, 8'd0,
                     dllce_pkg::ST_NOP, 1'b0));
    dir.push_back(mk(dllce_pkg::FN_TOP_TERM,   8'd0,   1'b1, 1, 8'd0,
                     dllce_pkg::ST_NOP, 1'b0));
    dir.push_back(mk(4'd15,                    8'hff,  1'b1, 1, 8'd0,
                     dllce_pkg::ST_NOP, 1'b0));
    dir.push_back(mk(dllce_pkg::FN_INS_FIRST,  8'd255, 1'b0, 1, 8'd0,
                     dllce_pkg::ST_DONE, 1'b0));
    dir.push_back(mk(dllce_pkg::FN_INS_LAST,   8'd0,   1'b0, 1, 8'd0,
                     dllce_pkg::ST_DONE, 1'b0));
    dir.push_back(mk(dllce_pkg::FN_TOP_TERM,   8'd0,   1'b0, 1, 8'd0,
                     dllce_pkg::ST_NOP, 1'b0));
    dir.push_back(mk(dllce_pkg::FN_GET_FIRST,  8'd0,   1'b0, 1, 8'd255,
                     dllce_pkg::ST_DONE, 1'b0));
    dir.push_back(mk(dllce_pkg::FN_LAST,       8'd0,   1'b0, 1, 8'd0,
                     dllce_pkg::ST_DONE, 1'b1));
    dir.push_back(mk(dllce_pkg::FN_INS_BEFORE, 8'd105, 1'b0, 0, 8'd0,
                     dllce_pkg::ST_DONE, 1'b0));
    dir.push_back(mk(dllce_pkg::FN_INS_AFTER,  8'd36,  1'b0, 0, 8'd0,
                     dllce_pkg::ST_DONE, 1'b0));
    dir.push_back(mk(dllce_pkg::FN_DEL_AFTER,  8'd0,   1'b0, 1, 8'd36,
                     dllce_pkg::ST_DONE, 1'b1));
    dir.push_back(mk(dllce_pkg::FN_DEL_BEFORE, 8'd0,   1'b0, 1, 8'd105,
                     dllce_pkg::ST_DONE, 1'b1));
    dir.push_back(mk(dllce_pkg::FN_INS_LAST,   8'd47,  1'b0, 0, 8'd0,
                     dllce_pkg::ST_DONE, 1'b0));
    dir.push_back(mk(dllce_pkg::FN_TOP_TERM,   8'd0,   1'b1, 1, 8'd47,
                     dllce_pkg::ST_DONE, 1'b1));
    dir.push_back(mk(dllce_pkg::FN_TOP_TERM,   8'd0,   1'b0, 0, 8'd0,
                     dllce_pkg::ST_DONE, 1'b0));
    dir.push_back(mk(dllce_pkg::FN_DEL_LAST,   8'd0,   1'b0, 1, 8'd47,
                     dllce_pkg::ST_DONE, 1'b0));
    dir.push_back(mk(dllce_pkg::FN_DEL_FIRST,  8'd0,   1'b0, 0, 8'd0,
                     dllce_pkg::ST_DONE, 1'b0));
    dir.push_back(mk(dllce_pkg::FN_GET_LAST,   8'd0,   1'b0, 1, 8'd0,
                     dllce_pkg::ST_DONE, 1'b0));
    dir.push_back(mk(dllce_pkg::FN_CLEAR,      8'd0,   1'b0, 1, 8'd0,
                     dllce_pkg::ST_DONE, 1'b0));
    dir.push_back(mk(4'd14,                    8'd0,   1'b0, 1, 8'd0,
                     dllce_pkg::ST_NOP, 1'b0));
    foreach (dir[i]) send_txn(dir[i].t, 1'b1, dir[i].has_gold, dir[i].gold);

    // Fill the pool to exhaustion, probe the full error, then drain half of it.
    for (k = 0; k < NPOOL + 2; k++)
      send_txn('{func: dllce_pkg::FN_INS_LAST, data_in: 8'($urandom_range(0, 255)),
                 from_last: 1'b0}, 1'b0, 1'b0, '0);
    send_txn('{func: dllce_pkg::FN_FIRST, data_in: 8'd0, from_last: 1'b0},
             1'b0, 1'b0, '0);
    send_txn('{func: dllce_pkg::FN_INS_AFTER, data_in: 8'd1, from_last: 1'b0},
             1'b0, 1'b0, '0);
    send_txn('{func: dllce_pkg::FN_TOP_TERM, data_in: 8'd0, from_last: 1'b1},
             1'b0, 1'b0, '0);
    for (k = 0; k < NPOOL / 2; k++)
      send_txn('{func: 4'($urandom_range(6, 7)), data_in: 8'd0, from_last: 1'b0},
               1'b1, 1'b0, '0);

    // Hold off until the engine has answered everything outstanding.
    start <= 1'b0;
    @(negedge clk);
    while (expected_q.size() != 0) @(negedge clk);

    for (k = 0; k < 1700; k++) send_txn(rand_txn(), ($urandom_range(0, 4) != 0),
                                        1'b0, '0);
    start <= 1'b0;

    k = 0;
    while (expected_q.size() != 0 && k < 2000) begin
      @(posedge clk);
      k++;
    end
    repeat (300) @(posedge clk);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
